// ===== design/xy2_100_frame_pin_encoder_macros.svh =====
// Assertion macros shared by the frame pin encoder.
`ifndef XY2_100_FRAME_PIN_ENCODER_MACROS_SVH
`define XY2_100_FRAME_PIN_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define XY2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define XY2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/xy2_pkg.sv =====
// Shared types, constants and pattern tables of the XY2-100 frame pin encoder.
`timescale 1ns / 1ps

package xy2_pkg;

  localparam int unsigned CoordW         = 16;
  localparam int unsigned FrameBits      = 20;
  localparam int unsigned ResultsPerItem = 2 * FrameBits;
  localparam int unsigned QueueDepthDef  = 2;

  localparam logic [2:0]        FrameHeader = 3'b001;
  localparam logic [CoordW-1:0] SignFlip    = 16'h8000;

  typedef struct packed {
    logic [CoordW-1:0] x_pos;
    logic [CoordW-1:0] y_pos;
  } in_t;

  typedef struct packed {
    logic [7:0] pin_pattern;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [FrameBits-1:0] fx;
    logic [FrameBits-1:0] fy;
  } frame_t;

  localparam logic [15:0] SyncHighTab [4] = '{16'hd2c3, 16'h9687, 16'h5a4b, 16'h1e0f};
  localparam logic [15:0] SyncLowTab  [4] = '{16'hf0e1, 16'hb4a5, 16'h7869, 16'h3c2d};

  // Header 001, data MSB first, then a parity bit that makes the frame even.
  function automatic logic [FrameBits-1:0] build_frame(input logic [CoordW-1:0] data);
    build_frame = {FrameHeader, data, ~(^data)};
  endfunction

  function automatic logic [15:0] bit_pattern(input logic [1:0] sel, input logic sync_low);
    bit_pattern = sync_low ? SyncLowTab[sel] : SyncHighTab[sel];
  endfunction

endpackage

// ===== design/xy2_front.sv =====
// Front end: holds the sign mode and turns one position request into two frames.
`timescale 1ns / 1ps

module xy2_front import xy2_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  input  in_t    in_i,
  output frame_t frame_o
);

  logic              coord_signed_q;
  logic [CoordW-1:0] flip;
  logic [CoordW-1:0] x_data;
  logic [CoordW-1:0] y_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      coord_signed_q <= cfg_wdata_i;
    end
  end

  // Flipping the MSB maps two's complement onto offset binary.
  assign flip   = coord_signed_q ? SignFlip : '0;
  assign x_data = in_i.x_pos ^ flip;
  assign y_data = in_i.y_pos ^ flip;

  assign frame_o.fx = build_frame(x_data);
  assign frame_o.fy = build_frame(y_data);

endmodule

// ===== design/xy2_queue.sv =====
// Short frame queue between the front end and the serializer.
`timescale 1ns / 1ps

module xy2_queue import xy2_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef  // at least 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/xy2_back.sv =====
// Serializer: walks a frame pair MSB first and emits two pin patterns per bit.
`timescale 1ns / 1ps

module xy2_back import xy2_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  frame_t frame_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   empty_o,
  output out_t   result_o
);

  localparam int unsigned CntW = $clog2(ResultsPerItem);
  localparam logic [CntW-1:0] CntLast   = CntW'(ResultsPerItem - 1);
  localparam logic [CntW-2:0] ParityPos = (CntW - 1)'(FrameBits - 1);

  logic                 busy_q;
  logic [CntW-1:0]      cnt_q;
  logic [FrameBits-1:0] fx_q, fy_q;
  logic                 take;
  logic                 load;
  logic [15:0]          pat;

  assign take    = pop_i && busy_q;
  assign load    = valid_i && (!busy_q || (take && cnt_q == CntLast));
  assign ready_o = load;
  assign empty_o = !busy_q;

  // The parity bit is the last bit of the frame and is sent with the sync-low table.
  assign pat = bit_pattern({fy_q[FrameBits-1], fx_q[FrameBits-1]},
                           cnt_q[CntW-1:1] == ParityPos);

  assign result_o.pin_pattern = cnt_q[0] ? pat[15:8] : pat[7:0];
  assign result_o.last        = (cnt_q == CntLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (take) begin
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fx_q <= frame_i.fx;
      fy_q <= frame_i.fy;
    end else if (take && cnt_q[0]) begin
      fx_q <= {fx_q[FrameBits-2:0], 1'b0};
      fy_q <= {fy_q[FrameBits-2:0], 1'b0};
    end
  end

endmodule

// ===== design/xy2_100_frame_pin_encoder.sv =====
// Top level of the XY2-100 frame pin encoder.
//
// Input channel: a position request (in_i) is taken at a rising edge with
// push high and full low. Output channel: while empty is low, result_o holds
// the oldest pin pattern; it is taken at a rising edge with pop high.
// Each position yields 40 pin patterns: 20 frame bits, low byte then high
// byte, with last set on the 40th.
// With the block idle, an accepted position is first written to the frame
// queue, then loaded into the serializer's registers that drive result_o.
// Throughput: one pattern per cycle while pop stays high; the serializer's
// 40-step counter walks through each position's patterns.
// A short frame queue lets new positions be accepted while a frame pair is
// still being sent. When pop is low the current pattern simply holds, and
// push sees full once the queue is filled.
// cfg_we_i writes cfg_wdata_i to the sign mode; write it only while idle.
// Reset clears the sign mode to unsigned and empties queue and serializer.
`timescale 1ns / 1ps

module xy2_100_frame_pin_encoder import xy2_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  output logic empty,
  input  logic pop,
  output out_t result_o
);

  `include "xy2_100_frame_pin_encoder_macros.svh"

  frame_t front_frame;
  frame_t queue_frame;
  logic   queue_valid;
  logic   back_ready;

  xy2_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .frame_o     (front_frame)
  );

  xy2_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_frame),
    .full_o  (full),
    .pop_i   (back_ready),
    .valid_o (queue_valid),
    .data_o  (queue_frame)
  );

  xy2_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (queue_valid),
    .frame_i  (queue_frame),
    .ready_o  (back_ready),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result_o)
  );

  // The serializer grabs a waiting frame as soon as it is idle, so a full
  // queue always means a frame pair is being sent.
  `XY2_ASSERT_NOW(a_full_means_busy, full, !empty, "queue full while serializer idle")

  // An accepted request is either queued or already being serialized.
  `XY2_ASSERT_NEXT(a_push_lands, push && !full, queue_valid || !empty,
                   "accepted request vanished")

  // Taking the last pattern with nothing queued leaves the output empty.
  `XY2_ASSERT_NEXT(a_last_drains, pop && !empty && result_o.last && !queue_valid, empty,
                   "serializer stayed busy after final pattern")

  // A frame only moves to the serializer when it can start it.
  `XY2_ASSERT_NOW(a_load_when_free, back_ready,
                  queue_valid && (empty || (pop && result_o.last)),
                  "frame loaded while serializer busy")

endmodule

// ===== bench/xy2_100_frame_pin_encoder_checker.sv =====
// Scoreboard for the XY2-100 frame pin encoder: predicts pin patterns and compares them.
`timescale 1ns / 1ps

module xy2_100_frame_pin_encoder_checker import xy2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic push_i,
  input  logic full_i,
  input  in_t  in_i,
  input  logic empty_i,
  input  logic pop_i,
  input  out_t result_i,
  output int   err_cnt_o,
  output int   pending_o
);

  localparam logic [15:0] HighPat [4] = '{16'hd2c3, 16'h9687, 16'h5a4b, 16'h1e0f};
  localparam logic [15:0] LowPat  [4] = '{16'hf0e1, 16'hb4a5, 16'h7869, 16'h3c2d};

  logic signed_mode;
  out_t pattern_q [$];
  int   errors;

  // Header 001, sixteen data bits, and a parity bit that leaves the frame even.
  function automatic logic [19:0] galvo_frame(input logic [15:0] coord);
    logic [19:0] frame;
    frame = {3'b001, coord, 1'b0};
    frame[0] = ^frame;
    return frame;
  endfunction

  task automatic queue_patterns(input logic [15:0] x, input logic [15:0] y);
    logic [19:0] fx;
    logic [19:0] fy;
    logic [1:0]  sel;
    logic [15:0] pat;
    out_t        lo_half;
    out_t        hi_half;
    if (signed_mode) begin
      x[15] = ~x[15];
      y[15] = ~y[15];
    end
    fx = galvo_frame(x);
    fy = galvo_frame(y);
    for (int pos = 19; pos >= 0; pos--) begin
      sel = {fy[pos], fx[pos]};
      pat = (pos == 0) ? LowPat[sel] : HighPat[sel];
      lo_half.pin_pattern = pat[7:0];
      lo_half.last        = 1'b0;
      hi_half.pin_pattern = pat[15:8];
      hi_half.last        = (pos == 0);
      pattern_q.push_back(lo_half);
      pattern_q.push_back(hi_half);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      signed_mode = 1'b0;
      pattern_q.delete();
      errors = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (pattern_q.size() == 0) begin
          $error("unexpected pattern %h (last %b)", result_i.pin_pattern, result_i.last);
          errors++;
        end else begin
          want = pattern_q.pop_front();
          if (result_i.pin_pattern !== want.pin_pattern) begin
            $error("pin_pattern: expected %h, actual %h", want.pin_pattern,
                   result_i.pin_pattern);
            errors++;
          end
          if (result_i.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, result_i.last);
            errors++;
          end
        end
      end
      // The sign mode in force at the edge applies to a request taken at that edge.
      if (push_i && !full_i) begin
        queue_patterns(in_i.x_pos, in_i.y_pos);
      end
      if (cfg_we_i) begin
        signed_mode = cfg_wdata_i;
      end
      err_cnt_o <= errors;
      pending_o <= pattern_q.size();
    end
  end

endmodule

// ===== bench/tb_xy2_100_frame_pin_encoder.sv =====
// Stimulus and verdict for the XY2-100 frame pin encoder.
`timescale 1ns / 1ps

module tb_xy2_100_frame_pin_encoder import xy2_pkg::*; ();

  localparam int WatchdogLimit = 4000;
  localparam int LongHold      = 400;
  localparam int HoldAfter     = 200;
  localparam int RandPhases    = 6;
  localparam int PhaseItems    = 72;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic push        = 1'b0;
  logic pop         = 1'b0;
  in_t  in_i        = '0;
  logic full;
  logic empty;
  out_t result_o;
  int   err_cnt;
  int   pending;
  int   items_sent = 0;

  xy2_100_frame_pin_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  xy2_100_frame_pin_encoder_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .full_i     (full),
    .in_i       (in_i),
    .empty_i    (empty),
    .pop_i      (pop),
    .result_i   (result_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      3: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Leaves push high so that back-to-back requests need no second assignment.
  task automatic send_position(input logic [15:0] x, input logic [15:0] y);
    push <= 1'b1;
    in_i <= '{x_pos: x, y_pos: y};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_sign_mode(input logic mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int burst;
    int gap;
    int left;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 10);
      if (burst > left) burst = left;
      repeat (burst) send_position(pick_coord(), pick_coord());
      left -= burst;
      case ($urandom_range(0, 4))
        0, 1: gap = 0;
        2, 3: gap = $urandom_range(1, 8);
        default: gap = $urandom_range(9, 60);
      endcase
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Receiver: stall density changes from stretch to stretch, plus one long hold-off.
  initial begin
    int pct;
    int span;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      span = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 75;
        2: pct = 50;
        default: pct = 20;
      endcase
      repeat (span) begin
        @(posedge clk_i);
        pop <= ($urandom_range(1, 100) <= pct);
      end
      if (!held && items_sent >= HoldAfter) begin
        held = 1'b1;
        @(posedge clk_i);
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) idle = 0;
      else idle++;
    end
    $display("xy2_100_frame_pin_encoder test failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unsigned mode: all-zero and all-one coordinates, mixed axes, both parity outcomes.
    set_sign_mode(1'b0);
    send_position(16'h0000, 16'h0000);
    send_position(16'hffff, 16'hffff);
    send_position(16'h0000, 16'hffff);
    send_position(16'hffff, 16'h0000);
    send_position(16'h8000, 16'h7fff);
    send_position(16'h7fff, 16'h8000);
    send_position(16'h0001, 16'h0003);
    send_position(16'haaaa, 16'h5555);
    send_position(16'h5555, 16'haaaa);
    send_position(16'h0100, 16'hfffe);
    wait_drained();

    // Signed mode: the flipped MSB turns the extremes around.
    set_sign_mode(1'b1);
    send_position(16'h8000, 16'h7fff);
    send_position(16'h7fff, 16'h8000);
    send_position(16'h0000, 16'hffff);
    send_position(16'hffff, 16'h0000);
    send_position(16'h0001, 16'h8001);
    wait_drained();

    for (int ph = 0; ph < RandPhases; ph++) begin
      set_sign_mode(ph[0]);
      random_phase(PhaseItems);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("xy2_100_frame_pin_encoder test passed");
    end else begin
      $display("xy2_100_frame_pin_encoder test failed");
    end
    $finish;
  end

endmodule
